// ===== rtl/isq_pkg.sv =====
// Shared constants, codes and types of the indexed sequence store.
package isq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_W     = ((CMD_W + DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W    = ((DATA_W + STAT_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_INS  = 2'd1,
    SHIFT_REM  = 2'd2
  } shift_op_t;

  typedef struct packed {
    shift_op_t          op;
    logic [CNT_W-1:0]   at;
    logic [DATA_W-1:0]  val;
  } cell_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    status_t                  status;
    logic signed [DATA_W-1:0] data;
  } result_t;

endpackage

// ===== rtl/isq_cell.sv =====
// One storage cell of the chain: holds one entry and shifts with its neighbors.
module isq_cell (
  input  logic                      clk,
  input  logic [isq_pkg::CNT_W-1:0] idx,
  input  isq_pkg::cell_ctl_t        ctl,
  input  logic [isq_pkg::DATA_W-1:0] left_q,
  input  logic [isq_pkg::DATA_W-1:0] right_q,
  output logic [isq_pkg::DATA_W-1:0] q
);

  logic [isq_pkg::DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      isq_pkg::SHIFT_INS: begin
        // open a gap at the insert point, take the left neighbor above it
        if (idx == ctl.at) begin
          q_next = ctl.val;
        end else if (idx > ctl.at) begin
          q_next = left_q;
        end
      end
      isq_pkg::SHIFT_REM: begin
        if (idx >= ctl.at) begin
          q_next = right_q;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/isq_out_buf.sv =====
// Output register with a skid stage for the result stream.
module isq_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  isq_pkg::result_t  res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output isq_pkg::result_t  out_res
);

  logic             skid_valid;
  isq_pkg::result_t skid_res;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        // output stalled: park the new result
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res;
      end
    end else if (push) begin
      skid_res <= res;
    end
  end

endmodule

// ===== rtl/indexed_sequence_store.sv =====
// Top level of the indexed sequence store: decode, cell chain and result output.
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells.
// Each transaction on the slave side carries one command (push back/front,
// insert, pop back/front, remove, read, clear) and produces exactly one result
// transaction on the master side: data, status and the new count. One command
// is taken per clock while s_tready is high; all cells shift toward their
// neighbors in parallel on insert or remove, and the result is formed at
// acceptance. A two-deep output buffer keeps the input open for one more
// command while a result waits; s_tready drops only when both result slots are full.
module indexed_sequence_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [isq_pkg::IN_W-1:0]   s_tdata,  // command[2:0], value[34:3], position[38:35]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [isq_pkg::OUT_W-1:0]  m_tdata   // data[31:0], status[33:32], count[38:34]
);

  logic                       accept;
  isq_pkg::cmd_t              cmd;
  logic [isq_pkg::DATA_W-1:0] value;
  logic [isq_pkg::POS_W-1:0]  pos;
  logic [isq_pkg::CNT_W-1:0]  occ;
  logic [isq_pkg::CNT_W-1:0]  occ_next;
  logic [isq_pkg::CNT_W-1:0]  pos_c;
  logic [isq_pkg::CNT_W-1:0]  rd_at;
  logic                       rd_en;
  logic                       full;
  logic                       empty;
  logic                       pos_ok;
  isq_pkg::status_t           status;
  isq_pkg::cell_ctl_t         ctl;
  isq_pkg::cell_ctl_t         cell_ctl;
  isq_pkg::result_t           res;
  isq_pkg::result_t           m_res;
  logic [isq_pkg::DATA_W-1:0] cell_q [isq_pkg::CAPACITY];

  assign accept = s_tvalid && s_tready;
  assign cmd    = isq_pkg::cmd_t'(s_tdata[isq_pkg::CMD_W-1:0]);
  assign value  = s_tdata[isq_pkg::CMD_W +: isq_pkg::DATA_W];
  assign pos    = s_tdata[isq_pkg::CMD_W + isq_pkg::DATA_W +: isq_pkg::POS_W];
  assign pos_c  = isq_pkg::CNT_W'(pos);
  assign full   = (occ == isq_pkg::CNT_W'(isq_pkg::CAPACITY));
  assign empty  = (occ == '0);
  assign pos_ok = isq_pkg::CMP_W'(pos) < isq_pkg::CMP_W'(occ);

  always_comb begin
    ctl.op   = isq_pkg::SHIFT_HOLD;
    ctl.at   = '0;
    ctl.val  = value;
    rd_en    = 1'b0;
    rd_at    = '0;
    status   = isq_pkg::ST_OK;
    occ_next = occ;
    unique case (cmd)
      isq_pkg::CMD_PUSH_BACK, isq_pkg::CMD_PUSH_FRONT, isq_pkg::CMD_INSERT: begin
        if (full) begin
          status = isq_pkg::ST_FULL;
        end else begin
          ctl.op = isq_pkg::SHIFT_INS;
          if (cmd == isq_pkg::CMD_PUSH_BACK) begin
            ctl.at = occ;
          end else if (cmd == isq_pkg::CMD_PUSH_FRONT) begin
            ctl.at = '0;
          end else begin
            // an index past the end appends
            ctl.at = pos_ok ? pos_c : occ;
          end
          occ_next = occ + 1'b1;
        end
      end
      isq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status = isq_pkg::ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          rd_at    = occ - 1'b1;
          occ_next = occ - 1'b1;
        end
      end
      isq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status = isq_pkg::ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          ctl.op   = isq_pkg::SHIFT_REM;
          occ_next = occ - 1'b1;
        end
      end
      isq_pkg::CMD_REMOVE: begin
        if (!pos_ok) begin
          status = isq_pkg::ST_RANGE;
        end else begin
          ctl.op   = isq_pkg::SHIFT_REM;
          ctl.at   = pos_c;
          occ_next = occ - 1'b1;
        end
      end
      isq_pkg::CMD_READ: begin
        if (!pos_ok) begin
          status = isq_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          rd_at = pos_c;
        end
      end
      isq_pkg::CMD_CLEAR: begin
        occ_next = '0;
      end
      default: status = isq_pkg::ST_OK;
    endcase
  end

  // cells move only on an accepted transaction
  always_comb begin
    cell_ctl = ctl;
    if (!accept) begin
      cell_ctl.op = isq_pkg::SHIFT_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (accept) begin
      occ <= occ_next;
    end
  end

  for (genvar i = 0; i < isq_pkg::CAPACITY; i++) begin : g_cell
    logic [isq_pkg::DATA_W-1:0] left_q;
    logic [isq_pkg::DATA_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == isq_pkg::CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    isq_cell u_cell (
      .clk     (clk),
      .idx     (isq_pkg::CNT_W'(i)),
      .ctl     (cell_ctl),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i])
    );
  end

  assign res.data   = rd_en ? cell_q[rd_at[isq_pkg::IDX_W-1:0]] : '0;
  assign res.status = status;
  assign res.count  = isq_pkg::COUNT_W'(occ_next);

  isq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res       (res),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (m_res)
  );

  assign m_tdata = isq_pkg::OUT_W'(m_res);

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("skid stage occupied while output register empty");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= isq_pkg::CNT_W'(isq_pkg::CAPACITY))
    else $error("occupancy above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == isq_pkg::CMD_CLEAR) |=> (occ == '0))
    else $error("clear did not empty the list");

  // a rejected push or insert leaves the occupancy where it was
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (status == isq_pkg::ST_FULL) |-> full ##1 $stable(occ))
    else $error("full status without a full list");
`endif

endmodule

// ===== bench/indexed_sequence_store_tb.sv =====
// Self-checking testbench for the indexed sequence store: directed and random command traffic.
module indexed_sequence_store_tb;

  localparam int EXP_DEPTH = 64;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [isq_pkg::IN_W-1:0]  s_tdata = '0;   // command[2:0], value[34:3], position[38:35]
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [isq_pkg::OUT_W-1:0] m_tdata;        // data[31:0], status[33:32], count[38:34]

  // Shadow copy of the stored sequence and its occupancy
  logic signed [isq_pkg::DATA_W-1:0] shadow_seq [isq_pkg::CAPACITY];
  int                                shadow_cnt = 0;
  // Expected results, written at input acceptance and read at output acceptance
  isq_pkg::result_t                  exp_ring [EXP_DEPTH];
  int                                exp_wr = 0;
  int                                exp_rd = 0;

  int  errors = 0;
  bit  steady = 1'b0;       // no idling on either side while set
  int  hold_cycles = 0;     // receiver hold-off, counted down by the receiver
  int  quiet_cycles = 0;
  bit  grow_mode = 1'b1;

  indexed_sequence_store dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic isq_pkg::result_t apply_command(isq_pkg::cmd_t op,
                                                     logic [isq_pkg::DATA_W-1:0] val,
                                                     logic [isq_pkg::POS_W-1:0] pos);
    isq_pkg::result_t r;
    int               at;
    r.data   = '0;
    r.status = isq_pkg::ST_OK;
    case (op)
      isq_pkg::CMD_PUSH_BACK, isq_pkg::CMD_PUSH_FRONT, isq_pkg::CMD_INSERT: begin
        if (shadow_cnt >= isq_pkg::CAPACITY) begin
          r.status = isq_pkg::ST_FULL;
        end else begin
          at = (op == isq_pkg::CMD_PUSH_BACK) ? shadow_cnt :
               (op == isq_pkg::CMD_PUSH_FRONT) ? 0 : int'(pos);
          if (at > shadow_cnt) at = shadow_cnt;
          for (int i = shadow_cnt; i > at; i--) shadow_seq[i] = shadow_seq[i-1];
          shadow_seq[at] = val;
          shadow_cnt++;
        end
      end
      isq_pkg::CMD_POP_BACK: begin
        if (shadow_cnt == 0) begin
          r.status = isq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_seq[shadow_cnt-1];
          shadow_cnt--;
        end
      end
      isq_pkg::CMD_POP_FRONT: begin
        if (shadow_cnt == 0) begin
          r.status = isq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_seq[0];
          for (int i = 0; i < shadow_cnt - 1; i++) shadow_seq[i] = shadow_seq[i+1];
          shadow_cnt--;
        end
      end
      isq_pkg::CMD_REMOVE: begin
        if (int'(pos) >= shadow_cnt) begin
          r.status = isq_pkg::ST_RANGE;
        end else begin
          for (int i = int'(pos); i < shadow_cnt - 1; i++) shadow_seq[i] = shadow_seq[i+1];
          shadow_cnt--;
        end
      end
      isq_pkg::CMD_READ: begin
        if (int'(pos) >= shadow_cnt) r.status = isq_pkg::ST_RANGE;
        else r.data = shadow_seq[pos];
      end
      default: begin
        shadow_cnt = 0;
      end
    endcase
    r.count = isq_pkg::COUNT_W'(shadow_cnt);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_command(isq_pkg::cmd_t op, logic [isq_pkg::DATA_W-1:0] val,
                              logic [isq_pkg::POS_W-1:0] pos);
    while (!steady && $urandom_range(99) < 6) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {1'b0, pos, val, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    exp_ring[exp_wr % EXP_DEPTH] = apply_command(op, val, pos);
    exp_wr++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_rd != exp_wr) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [isq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [isq_pkg::POS_W-1:0] pick_position();
    if (shadow_cnt > 0 && $urandom_range(3) != 0) begin
      return isq_pkg::POS_W'($urandom_range(shadow_cnt - 1));
    end
    return isq_pkg::POS_W'($urandom_range(15));
  endfunction

  function automatic isq_pkg::cmd_t pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 2) return isq_pkg::CMD_CLEAR;
    if (grow_mode) begin
      if (r < 22) return isq_pkg::CMD_PUSH_BACK;
      if (r < 40) return isq_pkg::CMD_PUSH_FRONT;
      if (r < 58) return isq_pkg::CMD_INSERT;
      if (r < 66) return isq_pkg::CMD_POP_BACK;
      if (r < 74) return isq_pkg::CMD_POP_FRONT;
      if (r < 82) return isq_pkg::CMD_REMOVE;
      return isq_pkg::CMD_READ;
    end
    if (r < 8)  return isq_pkg::CMD_PUSH_BACK;
    if (r < 14) return isq_pkg::CMD_PUSH_FRONT;
    if (r < 20) return isq_pkg::CMD_INSERT;
    if (r < 38) return isq_pkg::CMD_POP_BACK;
    if (r < 56) return isq_pkg::CMD_POP_FRONT;
    if (r < 76) return isq_pkg::CMD_REMOVE;
    return isq_pkg::CMD_READ;
  endfunction

  task automatic test_empty_errors();
    send_command(isq_pkg::CMD_POP_BACK, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF, 4'd15);
    send_command(isq_pkg::CMD_REMOVE, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd15);
    send_command(isq_pkg::CMD_CLEAR, 32'h0, 4'd0);
  endtask

  task automatic test_ordering_extremes();
    send_command(isq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
    send_command(isq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 4'd0);
    send_command(isq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd15);   // past the end: append
    send_command(isq_pkg::CMD_INSERT, 32'h0000_0000, 4'd1);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd3);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd4);
    send_command(isq_pkg::CMD_REMOVE, 32'h0, 4'd1);
    send_command(isq_pkg::CMD_REMOVE, 32'h0, 4'd3);
    send_command(isq_pkg::CMD_POP_BACK, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_POP_FRONT, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_POP_BACK, 32'h0, 4'd0);           // last element leaves
    send_command(isq_pkg::CMD_PUSH_BACK, 32'h5A5A_A5A5, 4'd0);
    send_command(isq_pkg::CMD_CLEAR, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd0);
  endtask

  // Stall the receiver at the start of the fill, then hit every full case.
  task automatic test_fill_under_backpressure();
    hold_cycles = 60;
    for (int i = 0; i < isq_pkg::CAPACITY; i++) begin
      send_command(isq_pkg::CMD_PUSH_BACK, pick_value(), 4'd0);
    end
    send_command(isq_pkg::CMD_PUSH_BACK, 32'h1234_5678, 4'd0);
    send_command(isq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 4'd0);
    send_command(isq_pkg::CMD_INSERT, 32'h1234_5678, 4'd7);
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd15);
    send_command(isq_pkg::CMD_REMOVE, 32'h0, 4'd15);
    send_command(isq_pkg::CMD_INSERT, 32'hDEAD_BEEF, 4'd0);
    wait_drained();
    send_command(isq_pkg::CMD_READ, 32'h0, 4'd0);
    send_command(isq_pkg::CMD_CLEAR, 32'h0, 4'd0);
  endtask

  task automatic test_random_traffic(int n_items);
    for (int i = 0; i < n_items; i++) begin
      steady = (i >= 300 && i < 450);
      if (shadow_cnt == isq_pkg::CAPACITY) grow_mode = 1'b0;
      else if (shadow_cnt == 0) grow_mode = 1'b1;
      else if ($urandom_range(99) < 3) grow_mode = ~grow_mode;
      send_command(pick_command(), pick_value(), pick_position());
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls plus the requested hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles--;
    end else if (steady) begin
      m_tready = 1'b1;
    end else begin
      m_tready = ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    isq_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (exp_rd == exp_wr) begin
        $error("unexpected result transaction: %h", m_tdata);
        errors++;
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (m_tdata[31:0] !== want.data) begin
          $error("data mismatch: expected %0d, got %0d", want.data, $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[33:32] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_tdata[33:32]);
          errors++;
        end
        if (m_tdata[38:34] !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, m_tdata[38:34]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_errors();
    test_ordering_extremes();
    test_fill_under_backpressure();
    test_random_traffic(705);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
